// File: design/ntwa_pkg.sv
// Shared types and constants of the neighbor table with aging.
`timescale 1ns / 1ps

package ntwa_pkg;

    // Commands carried by an input request.
    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_EXPIRE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Status codes carried by a result.
    typedef enum logic [2:0] {
        ST_REFRESH = 3'd0,
        ST_INSERT  = 3'd1,
        ST_DROP    = 3'd2,
        ST_EXPIRE  = 3'd3,
        ST_READ    = 3'd4
    } t_status;

    // States of the table engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD_MATCH,
        S_UPD_WRITE,
        S_EXP_SCAN,
        S_EXP_DONE,
        S_RD_SCAN
    } t_state;

    localparam logic [4:0]  MAX_READ      = 5'd16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
    localparam int          QUEUE_DEPTH   = 2;

    // A classified request waiting for the table engine.
    typedef struct packed {
        t_cmd               cmd;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [31:0]        time_now;
        logic [4:0]         limit;
    } t_req;

    // One result on its way out.
    typedef struct packed {
        t_status            status;
        logic               entry_valid;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [31:0]        seen;
        logic [4:0]         emitted_count;
        logic               last;
    } t_rsp;

    // Configuration write port.
    typedef struct packed {
        logic               we;
        logic [31:0]        wdata;
    } t_cfg;

endpackage

// File: design/ntwa_fifo.sv
// Small first-in first-out queue of registers used between the block's parts.
`timescale 1ns / 1ps

module ntwa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/ntwa_front.sv
// Front part: accepts input requests, drops unused commands and queues the rest.
`timescale 1ns / 1ps

module ntwa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_cmd,
    input  logic [47:0]        i_mac_in,
    input  logic signed [7:0]  i_rssi_in,
    input  logic [31:0]        i_time_now,
    input  logic [4:0]         i_max_read,
    output ntwa_pkg::t_req     o_req,
    output logic               o_req_empty,
    input  logic               i_req_pop
);

    import ntwa_pkg::*;

    logic             keep;
    t_req             req;
    logic [$bits(t_req)-1:0] q_data;

    always_comb begin
        unique case (i_cmd)
            CMD_UPDATE, CMD_EXPIRE, CMD_READ: keep = 1'b1;
            default:                          keep = 1'b0;
        endcase
    end

    always_comb begin
        req.cmd      = t_cmd'(i_cmd);
        req.mac      = i_mac_in;
        req.rssi     = i_rssi_in;
        req.time_now = i_time_now;
        req.limit    = (i_max_read > MAX_READ) ? MAX_READ : i_max_read;
    end

    ntwa_fifo #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (req),
        .o_full  (o_full),
        .i_pop   (i_req_pop),
        .o_data  (q_data),
        .o_empty (o_req_empty)
    );

    assign o_req = t_req'(q_data);

endmodule

// File: design/ntwa_back.sv
// Back part: the neighbor table itself and the engine that runs each command.
`timescale 1ns / 1ps

module ntwa_back #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ntwa_pkg::t_cfg i_cfg,
    input  ntwa_pkg::t_req i_req,
    input  logic           i_req_empty,
    output logic           o_req_pop,
    output ntwa_pkg::t_rsp o_rsp,
    output logic           o_rsp_push,
    input  logic           i_rsp_full
);

    import ntwa_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Table storage; contents are only looked at while the slot is valid.
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [47:0]            r_mac  [TABLE_SLOTS];
    logic signed [7:0]      r_rssi [TABLE_SLOTS];
    logic [31:0]            r_seen [TABLE_SLOTS];

    logic [31:0]   r_timeout;
    t_state        r_state;
    t_state        n_state;
    t_req          r_req;
    logic [IW-1:0] r_idx;
    logic [4:0]    r_count;

    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    logic          hit;
    logic [IW-1:0] hit_idx;
    logic          free;
    logic [IW-1:0] free_idx;

    logic [TABLE_SLOTS-1:0] valid_ge;
    logic [TABLE_SLOTS-1:0] valid_gt;
    logic [31:0]            age;
    logic [4:0]             next_count;

    logic done;
    logic wr_refresh;
    logic wr_insert;
    logic exp_clr;
    logic idx_inc;
    logic cnt_inc;

    // Parallel match across all slots; the lowest matching and lowest free slot win.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
            if (r_valid[j] && r_mac[j] == r_req.mac) begin
                hit     = 1'b1;
                hit_idx = IW'(j);
            end
            if (!r_valid[j]) begin
                free     = 1'b1;
                free_idx = IW'(j);
            end
        end
    end

    // Valid slots at or beyond, and strictly beyond, the scan position.
    always_comb begin
        for (int j = 0; j < TABLE_SLOTS; j++) begin
            valid_ge[j] = r_valid[j] && (IW'(j) >= r_idx);
            valid_gt[j] = r_valid[j] && (IW'(j) > r_idx);
        end
    end

    assign age        = r_req.time_now - r_seen[r_idx];
    assign next_count = r_count + 5'd1;

    always_comb begin
        n_state    = r_state;
        done       = 1'b0;
        o_req_pop  = 1'b0;
        o_rsp_push = 1'b0;
        o_rsp      = '0;
        wr_refresh = 1'b0;
        wr_insert  = 1'b0;
        exp_clr    = 1'b0;
        idx_inc    = 1'b0;
        cnt_inc    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
            end
            S_UPD_MATCH: begin
                n_state = S_UPD_WRITE;
            end
            S_UPD_WRITE: begin
                if (!i_rsp_full) begin
                    o_rsp_push = 1'b1;
                    o_rsp.last = 1'b1;
                    if (r_hit) begin
                        o_rsp.status = ST_REFRESH;
                        wr_refresh   = 1'b1;
                    end else if (r_free) begin
                        o_rsp.status = ST_INSERT;
                        wr_insert    = 1'b1;
                    end else begin
                        o_rsp.status = ST_DROP;
                    end
                    done = 1'b1;
                end
            end
            S_EXP_SCAN: begin
                exp_clr = r_valid[r_idx] && (age > r_timeout);
                if (r_idx == IW'(TABLE_SLOTS - 1)) begin
                    n_state = S_EXP_DONE;
                end else begin
                    idx_inc = 1'b1;
                end
            end
            S_EXP_DONE: begin
                if (!i_rsp_full) begin
                    o_rsp_push   = 1'b1;
                    o_rsp.status = ST_EXPIRE;
                    o_rsp.last   = 1'b1;
                    done         = 1'b1;
                end
            end
            S_RD_SCAN: begin
                if (r_req.limit == '0 || valid_ge == '0) begin
                    // Nothing to show: a single empty readout result.
                    if (!i_rsp_full) begin
                        o_rsp_push   = 1'b1;
                        o_rsp.status = ST_READ;
                        o_rsp.last   = 1'b1;
                        done         = 1'b1;
                    end
                end else if (r_valid[r_idx]) begin
                    if (!i_rsp_full) begin
                        o_rsp_push          = 1'b1;
                        o_rsp.status        = ST_READ;
                        o_rsp.entry_valid   = 1'b1;
                        o_rsp.mac           = r_mac[r_idx];
                        o_rsp.rssi          = r_rssi[r_idx];
                        o_rsp.seen          = r_seen[r_idx];
                        o_rsp.emitted_count = next_count;
                        o_rsp.last          = (next_count == r_req.limit) || (valid_gt == '0);
                        if (o_rsp.last) begin
                            done = 1'b1;
                        end else begin
                            idx_inc = 1'b1;
                            cnt_inc = 1'b1;
                        end
                    end
                end else begin
                    idx_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Take the next queued request as soon as the current one finishes.
        if ((r_state == S_IDLE || done) && !i_req_empty) begin
            o_req_pop = 1'b1;
            unique case (i_req.cmd)
                CMD_UPDATE: n_state = S_UPD_MATCH;
                CMD_EXPIRE: n_state = S_EXP_SCAN;
                CMD_READ:   n_state = S_RD_SCAN;
                default:    n_state = S_IDLE;
            endcase
        end else if (done) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.we) begin
                r_timeout <= i_cfg.wdata;
            end
            if (o_req_pop) begin
                r_idx   <= '0;
                r_count <= '0;
            end else begin
                if (idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cnt_inc) begin
                    r_count <= next_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_req <= i_req;
        end
        if (r_state == S_UPD_MATCH) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_free     <= free;
            r_free_idx <= free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_insert) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (exp_clr) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_insert) begin
            r_mac[r_free_idx]  <= r_req.mac;
            r_rssi[r_free_idx] <= r_req.rssi;
            r_seen[r_free_idx] <= r_req.time_now;
        end else if (wr_refresh) begin
            r_rssi[r_hit_idx] <= r_req.rssi;
            r_seen[r_hit_idx] <= r_req.time_now;
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_push |-> !i_rsp_full)
        else $error("result pushed into a full queue");

    a_read_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_SCAN) |-> (r_count <= r_req.limit))
        else $error("readout count ran past its limit");

    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_push && o_rsp.status == ST_INSERT) |=> r_valid[$past(r_free_idx)])
        else $error("inserted slot did not become valid");

endmodule

// File: design/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// input     in         push / full         i_cmd, i_mac_in, i_rssi_in, i_time_now, i_max_read
// result    out        empty / pop         o_status, o_entry_valid, o_mac_out, o_rssi_out,
//                                          o_seen_out, o_emitted_count, o_last
// config    in         i_cfg_we            i_cfg_wdata (timeout in milliseconds)
//
// An update request passes the match state, then the write state, in the table engine;
// the write waits while the result queue is full. An expire request walks the table one
// slot per cycle, then reports from a done state; a readout scans slot by slot and waits
// on a valid slot while the result queue is full. Reset clears all valid bits at once and
// loads the timeout with 30000; no clearing pass is needed. A two-entry request queue
// and a two-entry result queue let the input side and the result side stall on their own.

module neighbor_table_with_aging #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_cmd,
    input  logic [47:0]        i_mac_in,
    input  logic signed [7:0]  i_rssi_in,
    input  logic [31:0]        i_time_now,
    input  logic [4:0]         i_max_read,

    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic               o_entry_valid,
    output logic [47:0]        o_mac_out,
    output logic signed [7:0]  o_rssi_out,
    output logic [31:0]        o_seen_out,
    output logic [4:0]         o_emitted_count,
    output logic               o_last,

    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata
);

    import ntwa_pkg::*;

    t_req  req;
    logic  req_empty;
    logic  req_pop;
    t_rsp  rsp_in;
    logic  rsp_push;
    logic  rsp_full;
    t_rsp  rsp_out;
    t_cfg  cfg;
    logic [$bits(t_rsp)-1:0] rsp_q_data;

    assign cfg.we    = i_cfg_we;
    assign cfg.wdata = i_cfg_wdata;

    // The front accepts a request whenever its queue has room; unused command
    // codes are accepted and dropped there without producing a result.
    ntwa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_mac_in    (i_mac_in),
        .i_rssi_in   (i_rssi_in),
        .i_time_now  (i_time_now),
        .i_max_read  (i_max_read),
        .o_req       (req),
        .o_req_empty (req_empty),
        .i_req_pop   (req_pop)
    );

    // The back owns the table and runs one request at a time.
    ntwa_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (req),
        .i_req_empty (req_empty),
        .o_req_pop   (req_pop),
        .o_rsp       (rsp_in),
        .o_rsp_push  (rsp_push),
        .i_rsp_full  (rsp_full)
    );

    // Results wait here until the consumer pops them; the oldest is always on the ports.
    ntwa_fifo #(
        .WIDTH ($bits(t_rsp)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_data  (rsp_in),
        .o_full  (rsp_full),
        .i_pop   (pop),
        .o_data  (rsp_q_data),
        .o_empty (empty)
    );

    assign rsp_out         = t_rsp'(rsp_q_data);
    assign o_status        = rsp_out.status;
    assign o_entry_valid   = rsp_out.entry_valid;
    assign o_mac_out       = rsp_out.mac;
    assign o_rssi_out      = rsp_out.rssi;
    assign o_seen_out      = rsp_out.seen;
    assign o_emitted_count = rsp_out.emitted_count;
    assign o_last          = rsp_out.last;

endmodule
